// ===== hw/rtl/rlofm_pkg.sv =====
// Shared types and codes for the resting limit order fill matcher.
package rlofm_pkg;

  localparam int KEY_W = 13;

  localparam logic [1:0] REQ_SEND     = 2'd0;
  localparam logic [1:0] REQ_CANCEL   = 2'd1;
  localparam logic [1:0] REQ_SNAPSHOT = 2'd2;

  typedef enum logic [2:0] {
    RES_ACCEPTED = 3'd0,
    RES_REJECTED = 3'd1,
    RES_CANCELED = 3'd2,
    RES_FILL     = 3'd3,
    RES_NO_FILL  = 3'd4
  } res_kind_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [31:0]      price;
    logic [31:0]      size;
    logic [31:0]      ident;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic valid;
  } flag_t;

  typedef struct packed {
    logic      req_ready;
    logic      clear_wr;
    logic      scan_start;
    logic      scan_stop;
    logic      send_eval;
    logic      cancel_eval;
    logic      match_eval;
    logic      min_eval;
    logic      send_commit;
    logic      fill_commit;
    logic      load;
    res_kind_t load_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       req_valid;
    logic [1:0] req_type;
    logic       clear_done;
    logic       scan_done;
    logic       slot_free;
    logic       hits_zero;
    logic       hit_last;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/rlofm_if.sv =====
// Request and result channel interfaces of the fill matcher.
interface rlofm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  instrument;
  logic [3:0]  venue;
  logic        side;
  logic [31:0] limit_price;
  logic [31:0] quantity;
  logic [31:0] cancel_id;
  logic        bid_present;
  logic [31:0] best_bid;
  logic        ask_present;
  logic [31:0] best_ask;

  modport source (
    output valid, req_type, instrument, venue, side, limit_price, quantity, cancel_id,
           bid_present, best_bid, ask_present, best_ask,
    input  ready
  );
  modport sink (
    input  valid, req_type, instrument, venue, side, limit_price, quantity, cancel_id,
           bid_present, best_bid, ask_present, best_ask,
    output ready
  );
endinterface

interface rlofm_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         result_kind;
  logic [31:0]        result_id;
  logic [7:0]         fill_instrument;
  logic [3:0]         fill_venue;
  logic [31:0]        trade_price;
  logic signed [32:0] trade_qty;
  logic               last;

  modport source (
    output valid, result_kind, result_id, fill_instrument, fill_venue, trade_price,
           trade_qty, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, result_id, fill_instrument, fill_venue, trade_price,
           trade_qty, last,
    output ready
  );
endinterface

// ===== hw/rtl/rlofm_ctrl.sv =====
// Controller state machine of the fill matcher.
module rlofm_ctrl
  import rlofm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_CLEAR       = 11'b000_0000_0001,
    S_IDLE        = 11'b000_0000_0010,
    S_SEND_SCAN   = 11'b000_0000_0100,
    S_SEND_ACK    = 11'b000_0000_1000,
    S_SEND_FULL   = 11'b000_0001_0000,
    S_CANCEL_SCAN = 11'b000_0010_0000,
    S_CANCEL_ACK  = 11'b000_0100_0000,
    S_MATCH_SCAN  = 11'b000_1000_0000,
    S_MATCH_END   = 11'b001_0000_0000,
    S_MIN_SCAN    = 11'b010_0000_0000,
    S_FILL        = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.req_ready = 1'b1;
        if (status.req_valid) begin
          unique case (status.req_type)
            REQ_SEND: begin
              cmd.scan_start = 1'b1;
              state_next     = S_SEND_SCAN;
            end
            REQ_CANCEL: begin
              cmd.scan_start = 1'b1;
              state_next     = S_CANCEL_SCAN;
            end
            REQ_SNAPSHOT: begin
              cmd.scan_start = 1'b1;
              state_next     = S_MATCH_SCAN;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SEND_SCAN: begin
        cmd.send_eval = 1'b1;
        priority if (status.slot_free) begin
          cmd.scan_stop = 1'b1;
          state_next    = S_SEND_ACK;
        end else if (status.scan_done) begin
          state_next = S_SEND_FULL;
        end
      end
      S_SEND_ACK: begin
        if (status.out_free) begin
          cmd.load        = 1'b1;
          cmd.load_kind   = RES_ACCEPTED;
          cmd.send_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SEND_FULL: begin
        if (status.out_free) begin
          cmd.load      = 1'b1;
          cmd.load_kind = RES_REJECTED;
          state_next    = S_IDLE;
        end
      end
      S_CANCEL_SCAN: begin
        cmd.cancel_eval = 1'b1;
        if (status.scan_done) begin
          state_next = S_CANCEL_ACK;
        end
      end
      S_CANCEL_ACK: begin
        if (status.out_free) begin
          cmd.load      = 1'b1;
          cmd.load_kind = RES_CANCELED;
          state_next    = S_IDLE;
        end
      end
      S_MATCH_SCAN: begin
        cmd.match_eval = 1'b1;
        if (status.scan_done) begin
          state_next = S_MATCH_END;
        end
      end
      S_MATCH_END: begin
        if (status.hits_zero) begin
          if (status.out_free) begin
            cmd.load      = 1'b1;
            cmd.load_kind = RES_NO_FILL;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_MIN_SCAN;
        end
      end
      S_MIN_SCAN: begin
        cmd.min_eval = 1'b1;
        if (status.scan_done) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        if (status.out_free) begin
          cmd.load        = 1'b1;
          cmd.load_kind   = RES_FILL;
          cmd.fill_commit = 1'b1;
          if (status.hit_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_MIN_SCAN;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rlofm_dp.sv =====
// Datapath of the fill matcher: order table, slot scanner and result register.
module rlofm_dp
  import rlofm_pkg::*;
#(
  parameter int ORDER_CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  rlofm_req_if.sink   req,
  rlofm_res_if.source res,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status
);

  localparam int AW = $clog2(ORDER_CAPACITY);
  localparam int CW = $clog2(ORDER_CAPACITY + 1);
  localparam logic [AW-1:0] LAST = AW'(ORDER_CAPACITY - 1);

  entry_t entry_mem [ORDER_CAPACITY];
  flag_t  flag_mem  [ORDER_CAPACITY];
  entry_t entry_q;
  flag_t  flag_q;

  logic [7:0]  r_instr;
  logic [3:0]  r_venue;
  logic        r_side;
  logic [31:0] r_price;
  logic [31:0] r_qty;
  logic [31:0] r_cid;
  logic        r_bid_ok;
  logic [31:0] r_bid;
  logic        r_ask_ok;
  logic [31:0] r_ask;

  logic [AW-1:0] addr;
  logic [AW-1:0] addr_d;
  logic          rd_on;
  logic          rd_vld;
  logic [AW-1:0] free_addr;
  logic [31:0]   next_ident;
  logic [CW-1:0] hit_cnt;
  logic          best_vld;
  logic [AW-1:0] best_addr;
  entry_t        best;

  logic               out_valid;
  logic [2:0]         out_kind;
  logic [31:0]        out_id;
  logic [7:0]         out_instr;
  logic [3:0]         out_venue;
  logic [31:0]        out_price;
  logic signed [32:0] out_qty;
  logic               out_last;

  logic          req_fire;
  logic          out_free;
  logic          key_eq;
  logic          crossed;
  logic          hit_new;
  logic          cancel_hit;
  logic          flag_we;
  logic [AW-1:0] flag_wa;
  flag_t         flag_wd;

  assign req_fire  = cmd.req_ready & req.valid;
  assign req.ready = cmd.req_ready;
  assign out_free  = ~out_valid | res.ready;

  always_comb begin
    key_eq     = entry_q.key[KEY_W-1:1] == {r_instr, r_venue};
    crossed    = entry_q.key[0] ? (r_bid_ok && (r_bid >= entry_q.price))
                                : (r_ask_ok && (r_ask <= entry_q.price));
    hit_new    = flag_q.valid & key_eq & crossed;
    cancel_hit = flag_q.valid & (entry_q.ident == r_cid);
  end

  always_comb begin
    flag_we = 1'b0;
    flag_wa = addr_d;
    flag_wd = '0;
    priority if (cmd.clear_wr) begin
      flag_we = 1'b1;
      flag_wa = addr;
    end else if (cmd.cancel_eval && rd_vld && cancel_hit) begin
      flag_we = 1'b1;
    end else if (cmd.match_eval && rd_vld) begin
      flag_we       = 1'b1;
      flag_wd.hit   = hit_new;
      flag_wd.valid = flag_q.valid;
    end else if (cmd.send_commit) begin
      flag_we       = 1'b1;
      flag_wa       = free_addr;
      flag_wd.valid = 1'b1;
    end else if (cmd.fill_commit) begin
      flag_we = 1'b1;
      flag_wa = best_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    if (cmd.send_commit) begin
      entry_mem[free_addr] <= '{key:   {r_instr, r_venue, r_side},
                                price: r_price,
                                size:  r_qty,
                                ident: next_ident};
    end
    flag_q  <= flag_mem[addr];
    entry_q <= entry_mem[addr];
    addr_d  <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      rd_on  <= 1'b0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      addr   <= '0;
      rd_on  <= 1'b1;
      rd_vld <= 1'b0;
    end else if (cmd.scan_stop) begin
      rd_on  <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_on;
      if (rd_on) begin
        if (addr == LAST) begin
          rd_on <= 1'b0;
        end else begin
          addr <= addr + 1'b1;
        end
      end else if (cmd.clear_wr && (addr != LAST)) begin
        addr <= addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      r_instr  <= req.instrument;
      r_venue  <= req.venue;
      r_side   <= req.side;
      r_price  <= req.limit_price;
      r_qty    <= req.quantity;
      r_cid    <= req.cancel_id;
      r_bid_ok <= req.bid_present;
      r_bid    <= req.best_bid;
      r_ask_ok <= req.ask_present;
      r_ask    <= req.best_ask;
    end
    if (cmd.send_eval && rd_vld && !flag_q.valid) begin
      free_addr <= addr_d;
    end
    if (cmd.min_eval && rd_vld && flag_q.hit && (!best_vld || (entry_q.ident < best.ident))) begin
      best      <= entry_q;
      best_addr <= addr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_ident <= 32'd1;
      hit_cnt    <= '0;
      best_vld   <= 1'b0;
    end else begin
      if (cmd.send_commit) begin
        next_ident <= next_ident + 32'd1;
      end
      if (req_fire) begin
        hit_cnt <= '0;
      end else if (cmd.match_eval && rd_vld && hit_new) begin
        hit_cnt <= hit_cnt + 1'b1;
      end else if (cmd.fill_commit) begin
        hit_cnt <= hit_cnt - 1'b1;
      end
      if (cmd.scan_start) begin
        best_vld <= 1'b0;
      end else if (cmd.min_eval && rd_vld && flag_q.hit) begin
        best_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind  <= cmd.load_kind;
      out_id    <= '0;
      out_instr <= '0;
      out_venue <= '0;
      out_price <= '0;
      out_qty   <= '0;
      out_last  <= 1'b1;
      unique case (cmd.load_kind)
        RES_ACCEPTED: begin
          out_id <= next_ident;
        end
        RES_CANCELED: begin
          out_id <= r_cid;
        end
        RES_FILL: begin
          out_id    <= best.ident;
          out_instr <= best.key[KEY_W-1:5];
          out_venue <= best.key[4:1];
          out_price <= best.price;
          out_qty   <= best.key[0] ? -$signed({1'b0, best.size}) : $signed({1'b0, best.size});
          out_last  <= hit_cnt == CW'(1);
        end
        default: begin
          out_id <= '0;
        end
      endcase
    end
  end

  assign res.valid           = out_valid;
  assign res.result_kind     = out_kind;
  assign res.result_id       = out_id;
  assign res.fill_instrument = out_instr;
  assign res.fill_venue      = out_venue;
  assign res.trade_price     = out_price;
  assign res.trade_qty       = out_qty;
  assign res.last            = out_last;

  always_comb begin
    status.req_valid  = req.valid;
    status.req_type   = req.req_type;
    status.clear_done = addr == LAST;
    status.scan_done  = rd_vld && (addr_d == LAST);
    status.slot_free  = rd_vld && !flag_q.valid;
    status.hits_zero  = hit_cnt == '0;
    status.hit_last   = hit_cnt == CW'(1);
    status.out_free   = out_free;
  end

endmodule

// ===== hw/rtl/resting_limit_order_fill_matcher.sv =====
// Top level of the resting limit order fill matcher.
// Requests arrive as beats on the req channel and results leave as beats on
// the res channel, both valid/ready. A send stores an order in the lowest free
// slot of an ORDER_CAPACITY-entry table and answers with its new id, or with a
// reject when the table is full. A cancel clears every slot with that id and
// always answers. A snapshot fills crossed orders of its instrument and venue
// in ascending id order, one result beat per fill, with last set on the final
// beat; without fills it gives one beat of its own.
// Every pass walks the table one slot per cycle through the registered table
// read port. Each fill of a snapshot needs its own minimum search over the
// table. One request is worked on at a time. After reset every slot flag is
// cleared while req.ready stays low. A stalled receiver holds the result
// register; the matcher then waits before loading the next result beat.
module resting_limit_order_fill_matcher
  import rlofm_pkg::*;
#(
  parameter int ORDER_CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  rlofm_req_if.sink   req,
  rlofm_res_if.source res
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rlofm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  rlofm_dp #(
    .ORDER_CAPACITY (ORDER_CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .res    (res),
    .cmd    (cmd),
    .status (status)
  );

endmodule
